// ----- sv/adc_serial_readout_sequencer_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the serial ADC readout sequencer
// Concurrent checks sampled on the rising edge of clk.
// ---------------------------------------------------------------------------
`ifndef ADC_SERIAL_READOUT_SEQUENCER_TOP_MACROS_SVH
`define ADC_SERIAL_READOUT_SEQUENCER_TOP_MACROS_SVH

// Check a property, held off while reset is asserted.
`define ADCSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define ADCSR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/adcsr_pkg.sv -----
// ---------------------------------------------------------------------------
// adcsr_pkg
// Types and constants of the serial ADC readout sequencer.
// ---------------------------------------------------------------------------
package adcsr_pkg;

  localparam int SAMPLE_W  = 20;
  localparam int WAIT_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd1;

  // Wait lengths in ticks
  localparam logic [WAIT_W-1:0] WaitPwrFast    = 20'd55000;
  localparam logic [WAIT_W-1:0] WaitPwrSlow    = 20'd410000;
  localparam logic [WAIT_W-1:0] WaitCalFast    = 20'd110000;
  localparam logic [WAIT_W-1:0] WaitCalSlow    = 20'd810000;
  localparam logic [WAIT_W-1:0] WaitWakeFast   = 20'd50000;
  localparam logic [WAIT_W-1:0] WaitWakeSlow   = 20'd400000;
  localparam logic [WAIT_W-1:0] WaitPdwn       = 20'd30;
  localparam logic [WAIT_W-1:0] WaitStby       = 20'd25;
  localparam logic [WAIT_W-1:0] WaitStbyCal    = 20'd24;

  typedef enum logic [3:0] {
    CMD_NONE        = 4'd0,
    CMD_PWR_UP      = 4'd1,
    CMD_READ        = 4'd2,
    CMD_OFFSET_CAL  = 4'd3,
    CMD_STBY_ON     = 4'd4,
    CMD_STBY_OFF    = 4'd5,
    CMD_STBYCAL_ON  = 4'd6,
    CMD_STBYCAL_OFF = 4'd7,
    CMD_PDWN_ON     = 4'd8,
    CMD_PDWN_OFF    = 4'd9
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_LEAD,
    PH_HIGH,
    PH_LOW,
    PH_DELAY
  } phase_t;

  typedef struct packed {
    logic [3:0] func;
    logic       drdy_dout;
  } in_item_t;

  typedef struct packed {
    logic                       sclk;
    logic                       pdwn;
    logic                       gain_pin;
    logic                       speed_pin;
    logic                       busy_res;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] sample;
  } out_item_t;

endpackage

// ----- sv/adc_serial_readout_sequencer_top.sv -----
// ---------------------------------------------------------------------------
// adc_serial_readout_sequencer_top
// Pin-level sequencer that bit-bangs a delta-sigma ADC, one tick per item.
// ---------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------
//   in_      | input     | in_valid / in_stall  | func, drdy_dout (one tick)
//   out_     | output    | out_valid / out_stall| pin levels, busy, sample
//   cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The sequencer state and the output register are updated together at the edge
// that accepts an item, so one item per cycle flows while in_stall is low.
// Every accepted item yields exactly one result item; waits of the sequence are
// counted in items, not in clock cycles.
// rst_n is synchronous and active low; no clearing pass is needed.
// A result held under out_stall blocks the input: in_stall = out_valid & out_stall.
//
`include "adc_serial_readout_sequencer_top_macros.svh"

module adc_serial_readout_sequencer_top #(
  parameter int DATA_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input tick channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  adcsr_pkg::in_item_t             in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output adcsr_pkg::out_item_t            out_data,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [adcsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adcsr_pkg::CFG_DAT_W-1:0] cfg_data
);

  // bit counter must hold values up to DATA_BITS+6
  localparam int CW = $clog2(DATA_BITS + 7);
  localparam int SW = adcsr_pkg::SAMPLE_W;
  localparam int WW = adcsr_pkg::WAIT_W;

  localparam logic [CW-1:0] DataBitsC = CW'(DATA_BITS);

  // ---- state ---------------------------------------------------------------
  adcsr_pkg::phase_t phase_r, phase_nxt;
  adcsr_pkg::cmd_t   pend_r, pend_nxt;
  logic [CW-1:0]        bit_r, bit_nxt;
  logic [WW-1:0]        wait_r, wait_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic                 clk_lvl_r, clk_lvl_nxt;
  logic                 pwr_r, pwr_nxt;
  logic [SW-1:0]        result_r, result_nxt;
  logic                 gain_r, speed_r;
  logic                 out_valid_r;
  adcsr_pkg::out_item_t out_data_r, out_data_nxt;

  logic          in_acc;
  logic          fin;
  logic          smp_now;
  logic [SW-1:0] sample_nxt;
  logic [CW-1:0] pulses;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- configuration registers ---------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= 1'b0;
      speed_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == adcsr_pkg::REG_GAIN) begin
        gain_r <= cfg_data[0];
      end
      if (cfg_index == adcsr_pkg::REG_SPEED) begin
        speed_r <= cfg_data[0];
      end
    end
  end

  // ---- sample formatting: keep top bits or sign-extend ---------------------
  generate
    if (DATA_BITS >= SW) begin : g_trunc
      assign sample_nxt = shift_nxt[DATA_BITS-1 -: SW];
    end else begin : g_sext
      assign sample_nxt = {{(SW - DATA_BITS){shift_nxt[DATA_BITS-1]}}, shift_nxt};
    end
  endgenerate

  // number of clocks the pending command gives
  always_comb begin
    case (pend_r)
      adcsr_pkg::CMD_STBY_ON:    pulses = DataBitsC;
      adcsr_pkg::CMD_OFFSET_CAL,
      adcsr_pkg::CMD_STBYCAL_ON: pulses = CW'(DATA_BITS + 6);
      default:                   pulses = CW'(DATA_BITS + 1);
    endcase
  end

  // ---- sequencer next state ------------------------------------------------
  always_comb begin
    phase_nxt   = phase_r;
    pend_nxt    = pend_r;
    bit_nxt     = bit_r;
    wait_nxt    = wait_r;
    shift_nxt   = shift_r;
    clk_lvl_nxt = clk_lvl_r;
    pwr_nxt     = pwr_r;
    fin         = 1'b0;

    case (phase_r)
      adcsr_pkg::PH_IDLE: begin
        // take a command; codes outside one to nine are dropped
        if (in_data.func inside {[4'd1:4'd9]}) begin
          pend_nxt  = adcsr_pkg::cmd_t'(in_data.func);
          phase_nxt = adcsr_pkg::PH_DELAY;
          case (adcsr_pkg::cmd_t'(in_data.func))
            adcsr_pkg::CMD_PWR_UP: begin
              clk_lvl_nxt = 1'b0;
              pwr_nxt     = 1'b1;
              wait_nxt    = speed_r ? adcsr_pkg::WaitPwrFast : adcsr_pkg::WaitPwrSlow;
            end
            adcsr_pkg::CMD_STBY_OFF: begin
              clk_lvl_nxt = 1'b0;
              wait_nxt    = speed_r ? adcsr_pkg::WaitPwrFast : adcsr_pkg::WaitPwrSlow;
            end
            adcsr_pkg::CMD_STBYCAL_OFF: begin
              clk_lvl_nxt = 1'b0;
              wait_nxt    = speed_r ? adcsr_pkg::WaitCalFast : adcsr_pkg::WaitCalSlow;
            end
            adcsr_pkg::CMD_PDWN_ON: begin
              pwr_nxt  = 1'b0;
              wait_nxt = adcsr_pkg::WaitPdwn;
            end
            adcsr_pkg::CMD_PDWN_OFF: begin
              pwr_nxt  = 1'b1;
              wait_nxt = speed_r ? adcsr_pkg::WaitWakeFast : adcsr_pkg::WaitWakeSlow;
            end
            default: begin
              phase_nxt = adcsr_pkg::PH_WAIT;
            end
          endcase
        end
      end
      adcsr_pkg::PH_WAIT: begin
        if (!in_data.drdy_dout) begin
          if (pend_r == adcsr_pkg::CMD_OFFSET_CAL) begin
            phase_nxt = adcsr_pkg::PH_LEAD;
          end else begin
            clk_lvl_nxt = 1'b1;
            bit_nxt     = CW'(1);
            phase_nxt   = adcsr_pkg::PH_HIGH;
          end
        end
      end
      adcsr_pkg::PH_LEAD: begin
        clk_lvl_nxt = 1'b1;
        bit_nxt     = CW'(1);
        phase_nxt   = adcsr_pkg::PH_HIGH;
      end
      adcsr_pkg::PH_HIGH: begin
        // shift in data bits only; extra clocks are discarded
        if (bit_r <= DataBitsC) begin
          shift_nxt = {shift_r[DATA_BITS-2:0], in_data.drdy_dout};
        end
        if (bit_r >= pulses) begin
          if (pend_r == adcsr_pkg::CMD_STBY_ON) begin
            wait_nxt  = adcsr_pkg::WaitStby;
            phase_nxt = adcsr_pkg::PH_DELAY;
          end else if (pend_r == adcsr_pkg::CMD_STBYCAL_ON) begin
            wait_nxt  = adcsr_pkg::WaitStbyCal;
            phase_nxt = adcsr_pkg::PH_DELAY;
          end else begin
            clk_lvl_nxt = 1'b0;
            if (pend_r == adcsr_pkg::CMD_OFFSET_CAL) begin
              wait_nxt  = speed_r ? adcsr_pkg::WaitCalFast : adcsr_pkg::WaitCalSlow;
              phase_nxt = adcsr_pkg::PH_DELAY;
            end else begin
              fin = 1'b1;
            end
          end
        end else begin
          clk_lvl_nxt = 1'b0;
          phase_nxt   = adcsr_pkg::PH_LOW;
        end
      end
      adcsr_pkg::PH_LOW: begin
        clk_lvl_nxt = 1'b1;
        bit_nxt     = bit_r + CW'(1);
        phase_nxt   = adcsr_pkg::PH_HIGH;
      end
      adcsr_pkg::PH_DELAY: begin
        if (wait_r <= WW'(1)) begin
          wait_nxt = '0;
          fin      = 1'b1;
        end else begin
          wait_nxt = wait_r - WW'(1);
        end
      end
      default: begin
        phase_nxt = adcsr_pkg::PH_IDLE;
      end
    endcase

    // end of sequence: back to idle, publish the sample for reading commands
    if (fin) begin
      phase_nxt = adcsr_pkg::PH_IDLE;
      bit_nxt   = '0;
    end
    smp_now = fin && (pend_r == adcsr_pkg::CMD_READ || pend_r == adcsr_pkg::CMD_OFFSET_CAL ||
                      pend_r == adcsr_pkg::CMD_STBY_ON || pend_r == adcsr_pkg::CMD_STBYCAL_ON);
    result_nxt = smp_now ? sample_nxt : result_r;

    out_data_nxt.sclk         = clk_lvl_nxt;
    out_data_nxt.pdwn         = pwr_nxt;
    out_data_nxt.gain_pin     = gain_r;
    out_data_nxt.speed_pin    = speed_r;
    out_data_nxt.busy_res     = (phase_nxt != adcsr_pkg::PH_IDLE);
    out_data_nxt.sample_valid = smp_now;
    out_data_nxt.sample       = result_nxt;
  end

  // ---- state and output registers ------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= adcsr_pkg::PH_IDLE;
      pend_r    <= adcsr_pkg::CMD_NONE;
      bit_r     <= '0;
      wait_r    <= '0;
      shift_r   <= '0;
      clk_lvl_r <= 1'b0;
      pwr_r     <= 1'b0;
      result_r  <= '0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      pend_r    <= pend_nxt;
      bit_r     <= bit_nxt;
      wait_r    <= wait_nxt;
      shift_r   <= shift_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      pwr_r     <= pwr_nxt;
      result_r  <= result_nxt;
    end
  end

  // hold the result while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  // ---- assertions ----------------------------------------------------------
  `ADCSR_ASSERT(a_idle_no_count, (phase_r == adcsr_pkg::PH_IDLE) |-> (bit_r == '0), "idle count")
  `ADCSR_ASSERT(a_low_phase_sclk, (phase_r == adcsr_pkg::PH_LOW) |-> !clk_lvl_r, "sclk high")
  `ADCSR_ASSERT(a_smp_idle, out_valid_r && out_data_r.sample_valid |-> !out_data_r.busy_res, "busy")
  `ADCSR_ASSERT(a_high_counted, (phase_r == adcsr_pkg::PH_HIGH) |-> (bit_r != '0), "no count")

endmodule
